@@ sv/ptt_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package ptt_pkg;

    // Lexer modes held between code units.
    typedef enum logic [2:0] {
        MODE_IDLE,
        MODE_ATOM,
        MODE_STR,
        MODE_ESC,
        MODE_AFTER_STR,
        MODE_AFTER_PLUS
    } ptt_mode_t;

    // Token kinds as they appear on the token_kind port.
    typedef enum logic [3:0] {
        K_OPEN   = 4'd0,
        K_CLOSE  = 4'd1,
        K_ACHAR  = 4'd2,
        K_AEND   = 4'd3,
        K_SBEGIN = 4'd4,
        K_SCHAR  = 4'd5,
        K_SEND   = 4'd6,
        K_END    = 4'd7,
        K_ERROR  = 4'd8
    } ptt_kind_t;

    localparam int unsigned MAX_EVENTS = 4;

    // Code units with a special meaning to the lexer.
    localparam logic [15:0] CU_TAB       = 16'h0009;
    localparam logic [15:0] CU_LF        = 16'h000A;
    localparam logic [15:0] CU_CR        = 16'h000D;
    localparam logic [15:0] CU_SPACE     = 16'h0020;
    localparam logic [15:0] CU_QUOTE     = 16'h0022;
    localparam logic [15:0] CU_OPEN      = 16'h0028;
    localparam logic [15:0] CU_CLOSE     = 16'h0029;
    localparam logic [15:0] CU_PLUS      = 16'h002B;
    localparam logic [15:0] CU_BSLASH    = 16'h005C;
    localparam logic [15:0] CU_LETTER_N  = 16'h006E;
    localparam logic [15:0] CU_LETTER_T  = 16'h0074;
    localparam logic [15:0] CU_ASCII_MAX = 16'h007F;
    localparam logic [15:0] CU_BOM       = 16'hFEFF;

    // One token event as it travels to the output port.
    typedef struct packed {
        ptt_kind_t   kind;
        logic [15:0] value;
        logic [15:0] err_line;
        logic [15:0] err_column;
        logic        last;
    } ptt_event_t;

    // All events caused by one code unit.
    typedef struct packed {
        logic [2:0]                       count;
        ptt_event_t [MAX_EVENTS-1:0]      ev;
    } ptt_batch_t;

endpackage

`default_nettype wire

@@ sv/ptt_lexer.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ptt_lexer
    import ptt_pkg::*;
#(
    parameter int POSITION_BITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_fire,
    input  wire logic [15:0] code_unit,
    input  wire logic        end_of_text,
    output ptt_batch_t       batch
);

    localparam logic [POSITION_BITS-1:0] POS_ONE = {{(POSITION_BITS-1){1'b0}}, 1'b1};

    typedef struct packed {
        logic       emit;
        ptt_event_t ev;
        ptt_mode_t  mode;
        logic       mark;
    } ptt_start_t;

    ptt_mode_t                mode_reg, mode_next;
    logic                     sap_reg, sap_next;
    logic [POSITION_BITS-1:0] line_reg, line_next;
    logic [POSITION_BITS-1:0] col_reg, col_next;
    logic [POSITION_BITS-1:0] sline_reg, sline_next;
    logic [POSITION_BITS-1:0] scol_reg, scol_next;
    logic [15:0]              err_line;
    logic [15:0]              err_col;

    function automatic logic is_space(input logic [15:0] c);
        if (c <= CU_ASCII_MAX) begin
            return (c == CU_SPACE) || (c >= CU_TAB && c <= CU_CR);
        end
        return (c == 16'h0085) || (c == 16'h00A0) || (c == 16'h1680) ||
               (c >= 16'h2000 && c <= 16'h200A) || (c == 16'h2028) ||
               (c == 16'h2029) || (c == 16'h202F) || (c == 16'h205F) ||
               (c == 16'h3000);
    endfunction

    function automatic ptt_event_t mk_ev(input ptt_kind_t k, input logic [15:0] v);
        ptt_event_t e;
        e.kind       = k;
        e.value      = v;
        e.err_line   = 16'h0000;
        e.err_column = 16'h0000;
        e.last       = 1'b0;
        return e;
    endfunction

    function automatic ptt_start_t start_tok(input logic [15:0] c);
        ptt_start_t s;
        s.emit = 1'b0;
        s.ev   = mk_ev(K_OPEN, 16'h0000);
        s.mode = MODE_IDLE;
        s.mark = 1'b0;
        if (is_space(c) || c == CU_BOM) begin
            s.mode = MODE_IDLE;
        end else if (c == CU_OPEN) begin
            s.emit = 1'b1;
        end else if (c == CU_CLOSE) begin
            s.emit = 1'b1;
            s.ev   = mk_ev(K_CLOSE, 16'h0000);
        end else if (c == CU_QUOTE) begin
            s.emit = 1'b1;
            s.ev   = mk_ev(K_SBEGIN, 16'h0000);
            s.mode = MODE_STR;
            s.mark = 1'b1;
        end else begin
            s.emit = 1'b1;
            s.ev   = mk_ev(K_ACHAR, c);
            s.mode = MODE_ATOM;
        end
        return s;
    endfunction

    // Error positions are reported on 16 bits, saturating.
    generate
        if (POSITION_BITS > 16) begin : g_sat
            assign err_line = (|sline_reg[POSITION_BITS-1:16]) ? 16'hFFFF : sline_reg[15:0];
            assign err_col  = (|scol_reg[POSITION_BITS-1:16]) ? 16'hFFFF : scol_reg[15:0];
        end else begin : g_ext
            assign err_line = 16'(sline_reg);
            assign err_col  = 16'(scol_reg);
        end
    endgenerate

    always_comb
    begin
        ptt_event_t ev_v [MAX_EVENTS];
        logic [2:0] n_v;
        ptt_start_t st_v;
        logic       sp_v;
        logic       stop_v;
        logic       mark_v;

        for (int i = 0; i < MAX_EVENTS; i++) begin
            ev_v[i] = mk_ev(K_OPEN, 16'h0000);
        end
        n_v    = 3'd0;
        st_v   = start_tok(code_unit);
        sp_v   = is_space(code_unit);
        stop_v = sp_v || code_unit == CU_OPEN || code_unit == CU_CLOSE;
        mark_v = 1'b0;

        mode_next  = mode_reg;
        sap_next   = sap_reg;
        line_next  = line_reg;
        col_next   = col_reg;

        if (end_of_text) begin
            unique case (mode_reg)
                MODE_ATOM:
                begin
                    ev_v[0] = mk_ev(K_AEND, 16'h0000);
                    n_v     = 3'd1;
                end
                MODE_STR, MODE_ESC:
                begin
                    ev_v[0]            = mk_ev(K_ERROR, 16'h0000);
                    ev_v[0].err_line   = err_line;
                    ev_v[0].err_column = err_col;
                    n_v                = 3'd1;
                end
                MODE_AFTER_STR:
                begin
                    ev_v[0] = mk_ev(K_SEND, 16'h0000);
                    n_v     = 3'd1;
                end
                MODE_AFTER_PLUS:
                begin
                    ev_v[0] = mk_ev(K_SEND, 16'h0000);
                    ev_v[1] = mk_ev(K_ACHAR, CU_PLUS);
                    ev_v[2] = mk_ev(K_AEND, 16'h0000);
                    n_v     = 3'd3;
                end
                default:
                begin
                    n_v = 3'd0;
                end
            endcase
            ev_v[n_v[1:0]] = mk_ev(K_END, 16'h0000);
            n_v            = n_v + 3'd1;
            mode_next      = MODE_IDLE;
            sap_next       = 1'b0;
            line_next      = POS_ONE;
            col_next       = POS_ONE;
        end else begin
            unique case (mode_reg)
                MODE_ATOM:
                begin
                    if (stop_v) begin
                        ev_v[0] = mk_ev(K_AEND, 16'h0000);
                        n_v     = 3'd1;
                        if (st_v.emit) begin
                            ev_v[1] = st_v.ev;
                            n_v     = 3'd2;
                        end
                        mode_next = st_v.mode;
                        mark_v    = st_v.mark;
                    end else begin
                        ev_v[0]   = mk_ev(K_ACHAR, code_unit);
                        n_v       = 3'd1;
                        mode_next = MODE_ATOM;
                    end
                end
                MODE_STR:
                begin
                    if (code_unit == CU_QUOTE) begin
                        mode_next = MODE_AFTER_STR;
                    end else if (code_unit == CU_BSLASH) begin
                        mode_next = MODE_ESC;
                    end else begin
                        ev_v[0] = mk_ev(K_SCHAR, code_unit);
                        n_v     = 3'd1;
                    end
                end
                MODE_ESC:
                begin
                    n_v = 3'd1;
                    if (code_unit == CU_QUOTE || code_unit == CU_BSLASH) begin
                        ev_v[0] = mk_ev(K_SCHAR, code_unit);
                    end else if (code_unit == CU_LETTER_N) begin
                        ev_v[0] = mk_ev(K_SCHAR, CU_LF);
                    end else if (code_unit == CU_LETTER_T) begin
                        ev_v[0] = mk_ev(K_SCHAR, CU_TAB);
                    end else begin
                        // Unknown escape: the backslash is kept as a character.
                        ev_v[0] = mk_ev(K_SCHAR, CU_BSLASH);
                        ev_v[1] = mk_ev(K_SCHAR, code_unit);
                        n_v     = 3'd2;
                    end
                    mode_next = MODE_STR;
                end
                MODE_AFTER_STR:
                begin
                    if (sp_v) begin
                        mode_next = MODE_AFTER_STR;
                    end else if (code_unit == CU_PLUS) begin
                        mode_next = MODE_AFTER_PLUS;
                        sap_next  = 1'b0;
                    end else begin
                        ev_v[0] = mk_ev(K_SEND, 16'h0000);
                        n_v     = 3'd1;
                        if (st_v.emit) begin
                            ev_v[1] = st_v.ev;
                            n_v     = 3'd2;
                        end
                        mode_next = st_v.mode;
                        mark_v    = st_v.mark;
                    end
                end
                MODE_AFTER_PLUS:
                begin
                    if (sp_v) begin
                        sap_next = 1'b1;
                    end else if (code_unit == CU_QUOTE) begin
                        // The next string joins the previous one.
                        mode_next = MODE_STR;
                        sap_next  = 1'b0;
                    end else begin
                        ev_v[0] = mk_ev(K_SEND, 16'h0000);
                        ev_v[1] = mk_ev(K_ACHAR, CU_PLUS);
                        n_v     = 3'd2;
                        if (sap_reg || stop_v) begin
                            ev_v[2] = mk_ev(K_AEND, 16'h0000);
                            n_v     = 3'd3;
                            if (st_v.emit) begin
                                ev_v[3] = st_v.ev;
                                n_v     = 3'd4;
                            end
                            mode_next = st_v.mode;
                            mark_v    = st_v.mark;
                        end else begin
                            ev_v[2]   = mk_ev(K_ACHAR, code_unit);
                            n_v       = 3'd3;
                            mode_next = MODE_ATOM;
                        end
                        sap_next = 1'b0;
                    end
                end
                default:
                begin
                    if (st_v.emit) begin
                        ev_v[0] = st_v.ev;
                        n_v     = 3'd1;
                    end
                    mode_next = st_v.mode;
                    mark_v    = st_v.mark;
                end
            endcase

            if (code_unit == CU_LF) begin
                if (line_reg != '1) begin
                    line_next = line_reg + POS_ONE;
                end
                col_next = POS_ONE;
            end else if (col_reg != '1) begin
                col_next = col_reg + POS_ONE;
            end
        end

        sline_next = mark_v ? line_reg : sline_reg;
        scol_next  = mark_v ? col_reg : scol_reg;

        for (int i = 0; i < MAX_EVENTS; i++) begin
            ev_v[i].last = ({1'b0, 2'(i)} == n_v - 3'd1);
            batch.ev[i]  = ev_v[i];
        end
        batch.count = n_v;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg  <= MODE_IDLE;
            sap_reg   <= 1'b0;
            line_reg  <= POS_ONE;
            col_reg   <= POS_ONE;
            sline_reg <= '0;
            scol_reg  <= '0;
        end else if (in_fire) begin
            mode_reg  <= mode_next;
            sap_reg   <= sap_next;
            line_reg  <= line_next;
            col_reg   <= col_next;
            sline_reg <= sline_next;
            scol_reg  <= scol_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/ptt_outq.sv @@
`timescale 1ns / 1ps
`default_nettype none

module ptt_outq
    import ptt_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       load,
    input  wire ptt_batch_t batch,
    input  wire logic       pop,
    output logic            can_load,
    output logic            not_empty,
    output ptt_event_t      head
);

    ptt_event_t q_reg [MAX_EVENTS];
    logic [2:0] cnt_reg, cnt_next;

    // The queue may be reloaded once its last waiting event leaves in this cycle.
    assign not_empty = (cnt_reg != 3'd0);
    assign can_load  = (cnt_reg == 3'd0) || (cnt_reg == 3'd1 && pop);
    assign head      = q_reg[0];

    always_comb
    begin
        cnt_next = cnt_reg;
        if (load) begin
            cnt_next = batch.count;
        end else if (pop) begin
            cnt_next = cnt_reg - 3'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cnt_reg <= 3'd0;
        end else begin
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load) begin
            for (int i = 0; i < MAX_EVENTS; i++) begin
                q_reg[i] <= batch.ev[i];
            end
        end else if (pop) begin
            for (int i = 0; i < MAX_EVENTS - 1; i++) begin
                q_reg[i] <= q_reg[i+1];
            end
        end
    end

endmodule

`default_nettype wire

@@ sv/paren_text_tokenizer.sv @@
`timescale 1ns / 1ps
`default_nettype none

// Streaming lexer for parenthesized text, one UTF-16 code unit per request.
// Input channel: in_valid/in_ready carry code_unit and end_of_text. A request
// with end_of_text set carries no character and closes the text.
// Output channel: out_valid/out_ready carry one token event per request:
// token_kind, char_value, error_line, error_column and last_of_run, which
// marks the final event caused by one input request.
// Each input request yields zero to four events. The lexer state and the
// events for a request are computed in the cycle it is accepted; the events
// land in a four-entry output queue and the first one is visible in the next cycle.
// Throughput: one input request per cycle while out_ready stays high and each
// request yields at most one event; a request yielding k events holds the
// output port until all k have left, and the next request is accepted in the
// cycle its last event leaves.
// A request is accepted only while the queue is empty or its last event leaves,
// so one that yields no event (skipped whitespace) also waits behind queued events.
// When the receiver holds out_ready low the queue keeps its contents and
// in_ready stays low until it drains.
// Reset puts the lexer between tokens at line 1, column 1 and empties the
// output queue; it is ready for input on the first cycle after reset.
module paren_text_tokenizer
    import ptt_pkg::*;
#(
    parameter int POSITION_BITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_ready,
    input  wire logic [15:0] code_unit,
    input  wire logic        end_of_text,
    output logic             out_valid,
    input  wire logic        out_ready,
    output logic [3:0]       token_kind,
    output logic [15:0]      char_value,
    output logic [15:0]      error_line,
    output logic [15:0]      error_column,
    output logic             last_of_run
);

    ptt_batch_t batch;
    ptt_event_t head;
    logic       in_fire;
    logic       pop;
    logic       can_load;
    logic       not_empty;

    assign in_ready = can_load;
    assign in_fire  = in_valid && can_load;
    assign pop      = not_empty && out_ready;

    ptt_lexer #(
        .POSITION_BITS(POSITION_BITS)
    ) u_lexer (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_fire     (in_fire),
        .code_unit   (code_unit),
        .end_of_text (end_of_text),
        .batch       (batch)
    );

    ptt_outq u_outq (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (in_fire),
        .batch     (batch),
        .pop       (pop),
        .can_load  (can_load),
        .not_empty (not_empty),
        .head      (head)
    );

    // The head of the queue drives the output port directly from registers.
    assign out_valid    = not_empty;
    assign token_kind   = head.kind;
    assign char_value   = head.value;
    assign error_line   = head.err_line;
    assign error_column = head.err_column;
    assign last_of_run  = head.last;

endmodule

`default_nettype wire

@@ sim/paren_text_tokenizer_checker.sv @@
`timescale 1ns / 1ps

// Watches both channels of the tokenizer, keeps its own copy of the lexer
// state and compares every token event with the oldest one still expected.
module paren_text_tokenizer_checker
    import ptt_pkg::*;
#(
    parameter int POSITION_BITS = 16
) (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    input  wire logic        in_ready,
    input  wire logic [15:0] code_unit,
    input  wire logic        end_of_text,
    input  wire logic        out_valid,
    input  wire logic        out_ready,
    input  wire logic [3:0]  token_kind,
    input  wire logic [15:0] char_value,
    input  wire logic [15:0] error_line,
    input  wire logic [15:0] error_column,
    input  wire logic        last_of_run,
    output int               fail_count,
    output int               pending_events
);

    localparam longint unsigned POS_MAX = (64'd1 << POSITION_BITS) - 64'd1;

    ptt_mode_t       mode;
    logic            plus_gap;
    longint unsigned line_no;
    longint unsigned col_no;
    longint unsigned quote_line;
    longint unsigned quote_col;

    ptt_event_t      expected_events[$];
    ptt_event_t      step_events[$];
    int              mismatches = 0;

    initial
    begin
        fail_count = 0;
        pending_events = 0;
    end

    function automatic bit is_blank(input logic [15:0] c);
        if (c <= CU_ASCII_MAX)
            return c == CU_SPACE || (c >= CU_TAB && c <= CU_CR);
        return c == 16'h0085 || c == 16'h00A0 || c == 16'h1680 ||
               (c >= 16'h2000 && c <= 16'h200A) || c == 16'h2028 ||
               c == 16'h2029 || c == 16'h202F || c == 16'h205F || c == 16'h3000;
    endfunction

    function automatic void add_event(input ptt_kind_t kind, input logic [15:0] value,
                                      input longint unsigned el, input longint unsigned ec);
        ptt_event_t ev;
        ev.kind       = kind;
        ev.value      = value;
        ev.err_line   = (el > 64'hFFFF) ? 16'hFFFF : el[15:0];
        ev.err_column = (ec > 64'hFFFF) ? 16'hFFFF : ec[15:0];
        ev.last       = 1'b0;
        step_events.insert(step_events.size(), ev);
    endfunction

    function automatic void begin_token(input logic [15:0] c);
        if (is_blank(c) || c == CU_BOM)
        begin
            mode = MODE_IDLE;
        end
        else if (c == CU_OPEN)
        begin
            add_event(K_OPEN, 16'h0, 0, 0);
            mode = MODE_IDLE;
        end
        else if (c == CU_CLOSE)
        begin
            add_event(K_CLOSE, 16'h0, 0, 0);
            mode = MODE_IDLE;
        end
        else if (c == CU_QUOTE)
        begin
            add_event(K_SBEGIN, 16'h0, 0, 0);
            quote_line = line_no;
            quote_col  = col_no;
            mode = MODE_STR;
        end
        else
        begin
            add_event(K_ACHAR, c, 0, 0);
            mode = MODE_ATOM;
        end
    endfunction

    function automatic void atom_step(input logic [15:0] c);
        if (is_blank(c) || c == CU_OPEN || c == CU_CLOSE)
        begin
            add_event(K_AEND, 16'h0, 0, 0);
            begin_token(c);
        end
        else
        begin
            add_event(K_ACHAR, c, 0, 0);
            mode = MODE_ATOM;
        end
    endfunction

    function automatic void lex_end_of_text();
        case (mode)
            MODE_ATOM:
                add_event(K_AEND, 16'h0, 0, 0);
            MODE_STR, MODE_ESC:
                add_event(K_ERROR, 16'h0, quote_line, quote_col);
            MODE_AFTER_STR:
                add_event(K_SEND, 16'h0, 0, 0);
            MODE_AFTER_PLUS:
            begin
                add_event(K_SEND, 16'h0, 0, 0);
                add_event(K_ACHAR, CU_PLUS, 0, 0);
                add_event(K_AEND, 16'h0, 0, 0);
            end
            default:
                ;
        endcase
        add_event(K_END, 16'h0, 0, 0);
        mode     = MODE_IDLE;
        plus_gap = 1'b0;
        line_no  = 1;
        col_no   = 1;
    endfunction

    function automatic void lex_unit(input logic [15:0] c);
        case (mode)
            MODE_ATOM:
                atom_step(c);
            MODE_STR:
                if (c == CU_QUOTE)
                    mode = MODE_AFTER_STR;
                else if (c == CU_BSLASH)
                    mode = MODE_ESC;
                else
                    add_event(K_SCHAR, c, 0, 0);
            MODE_ESC:
            begin
                if (c == CU_QUOTE || c == CU_BSLASH)
                begin
                    add_event(K_SCHAR, c, 0, 0);
                end
                else if (c == CU_LETTER_N)
                begin
                    add_event(K_SCHAR, CU_LF, 0, 0);
                end
                else if (c == CU_LETTER_T)
                begin
                    add_event(K_SCHAR, CU_TAB, 0, 0);
                end
                else
                begin
                    add_event(K_SCHAR, CU_BSLASH, 0, 0);
                    add_event(K_SCHAR, c, 0, 0);
                end
                mode = MODE_STR;
            end
            MODE_AFTER_STR:
            begin
                if (c == CU_PLUS)
                begin
                    mode     = MODE_AFTER_PLUS;
                    plus_gap = 1'b0;
                end
                else if (!is_blank(c))
                begin
                    add_event(K_SEND, 16'h0, 0, 0);
                    begin_token(c);
                end
            end
            MODE_AFTER_PLUS:
            begin
                if (is_blank(c))
                begin
                    plus_gap = 1'b1;
                end
                else if (c == CU_QUOTE)
                begin
                    mode     = MODE_STR;
                    plus_gap = 1'b0;
                end
                else
                begin
                    add_event(K_SEND, 16'h0, 0, 0);
                    add_event(K_ACHAR, CU_PLUS, 0, 0);
                    if (plus_gap)
                    begin
                        add_event(K_AEND, 16'h0, 0, 0);
                        begin_token(c);
                    end
                    else
                    begin
                        atom_step(c);
                    end
                    plus_gap = 1'b0;
                end
            end
            default:
                begin_token(c);
        endcase

        if (c == CU_LF)
        begin
            if (line_no < POS_MAX)
                line_no++;
            col_no = 1;
        end
        else if (col_no < POS_MAX)
        begin
            col_no++;
        end
    endfunction

    task automatic check_event();
        ptt_event_t want;
        if (expected_events.size() == 0)
        begin
            mismatches++;
            if (mismatches <= 10)
                $display("%0t: unexpected token event kind %0d char %h line %0d col %0d last %b",
                         $time, token_kind, char_value, error_line, error_column, last_of_run);
        end
        else
        begin
            want = expected_events.pop_front();
            if (token_kind !== want.kind || char_value !== want.value ||
                error_line !== want.err_line || error_column !== want.err_column ||
                last_of_run !== want.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display({"%0t: token event mismatch, expected kind %0d char %h ",
                              "line %0d col %0d last %b"},
                             $time, want.kind, want.value, want.err_line, want.err_column,
                             want.last);
                    $display("%0t: got kind %0d char %h line %0d col %0d last %b",
                             $time, token_kind, char_value, error_line, error_column,
                             last_of_run);
                end
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            mode       = MODE_IDLE;
            plus_gap   = 1'b0;
            line_no    = 1;
            col_no     = 1;
            quote_line = 0;
            quote_col  = 0;
            expected_events.delete();
        end
        else
        begin
            // Events leave at the earliest in the cycle after their request, so
            // the output side is settled before this edge's request is added.
            if (out_valid && out_ready)
                check_event();
            if (in_valid && in_ready)
            begin
                step_events.delete();
                if (end_of_text)
                    lex_end_of_text();
                else
                    lex_unit(code_unit);
                if (step_events.size() > 0)
                    step_events[step_events.size() - 1].last = 1'b1;
                while (step_events.size() > 0)
                    expected_events.insert(expected_events.size(), step_events.pop_front());
            end
        end
        fail_count     <= mismatches;
        pending_events <= expected_events.size();
    end

endmodule

@@ sim/paren_text_tokenizer_tb.sv @@
`timescale 1ns / 1ps

// Top of the tokenizer testbench. It builds the code unit stream, plays the
// event receiver and gives the verdict. All prediction and comparison lives
// in the checker instantiated beside the block.
module paren_text_tokenizer_tb;
    import ptt_pkg::*;

    // Requests to send in the random part.
    localparam int RANDOM_UNITS = 330;
    // Cycles allowed for the output queue to drain at the end.
    localparam int DRAIN_LIMIT = 5000;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [15:0] code_unit;
    logic        end_of_text;
    logic        out_valid;
    logic        out_ready = 1'b0;
    logic [3:0]  token_kind;
    logic [15:0] char_value;
    logic [15:0] error_line;
    logic [15:0] error_column;
    logic        last_of_run;

    int          fail_count;
    int          pending_events;

    // When set, neither side inserts idle cycles.
    bit          steady = 1'b0;
    int          units_sent = 0;

    paren_text_tokenizer u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .code_unit    (code_unit),
        .end_of_text  (end_of_text),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .token_kind   (token_kind),
        .char_value   (char_value),
        .error_line   (error_line),
        .error_column (error_column),
        .last_of_run  (last_of_run)
    );

    paren_text_tokenizer_checker u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .code_unit      (code_unit),
        .end_of_text    (end_of_text),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .token_kind     (token_kind),
        .char_value     (char_value),
        .error_line     (error_line),
        .error_column   (error_column),
        .last_of_run    (last_of_run),
        .fail_count     (fail_count),
        .pending_events (pending_events)
    );

    // 12 ns clock period.
    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // The event receiver stalls roughly 16 percent of the time. Its ready
    // changes only on the falling edge, so it is stable when sampled.
    always @(negedge clk)
        out_ready <= steady || ($urandom_range(0, 99) >= 16);

    // Sends one request. Idle cycles may come first, then valid rises with
    // its payload and holds until the block takes the request. Every falling
    // edge carries at most one assignment to in_valid.
    task automatic send_unit(input logic [15:0] cu, input logic eot);
        @(negedge clk);
        while (!steady && $urandom_range(0, 99) < 16)
        begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid    <= 1'b1;
        code_unit   <= cu;
        end_of_text <= eot;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
        units_sent++;
    endtask

    // The code unit rides along with an end-of-text request but is ignored,
    // so it is random to show that it really is.
    task automatic send_end();
        send_unit(16'($urandom_range(0, 16'hFFFF)), 1'b1);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_unit({8'h00, s[i]}, 1'b0);
    endtask

    // A whitespace code unit from across the whole set the lexer skips.
    function automatic logic [15:0] blank_unit();
        case ($urandom_range(0, 9))
            0: return CU_SPACE;
            1: return CU_TAB;
            2: return CU_LF;
            3: return CU_CR;
            4: return ($urandom_range(0, 1) != 0) ? 16'h000B : 16'h000C;
            5: return ($urandom_range(0, 1) != 0) ? 16'h0085 : 16'h00A0;
            6: return ($urandom_range(0, 1) != 0) ? 16'h1680 : 16'h2029;
            7: return 16'h2000 + 16'($urandom_range(0, 10));
            8: return ($urandom_range(0, 1) != 0) ? 16'h2028 : 16'h202F;
            default: return ($urandom_range(0, 1) != 0) ? 16'h205F : 16'h3000;
        endcase
    endfunction

    // A short run of whitespace.
    task automatic send_blanks(input int count);
        repeat (count)
            send_unit(blank_unit(), 1'b0);
    endtask

    // Mostly plain ASCII atom characters, sometimes wide ones from the top
    // of the code space (a byte-order mark among them, which is an ordinary
    // character inside an atom).
    function automatic logic [15:0] atom_unit();
        if ($urandom_range(0, 2) != 0)
            return 16'($urandom_range(16'h0041, 16'h007A));
        return 16'($urandom_range(16'h3001, 16'hFFFF));
    endfunction

    // String contents: escapes, printable ASCII, line feeds that move the
    // position counters, and fully random code units.
    task automatic send_string_body();
        repeat ($urandom_range(0, 5))
        begin
            case ($urandom_range(0, 5))
                0:
                begin
                    send_unit(CU_BSLASH, 1'b0);
                    case ($urandom_range(0, 4))
                        0: send_unit(CU_QUOTE, 1'b0);
                        1: send_unit(CU_BSLASH, 1'b0);
                        2: send_unit(CU_LETTER_N, 1'b0);
                        3: send_unit(CU_LETTER_T, 1'b0);
                        default: send_unit(16'($urandom_range(16'h0020, 16'h007E)), 1'b0);
                    endcase
                end
                1: send_unit(CU_LF, 1'b0);
                2: send_unit(16'($urandom_range(0, 16'hFFFF)), 1'b0);
                default: send_unit(16'($urandom_range(16'h0020, 16'h007E)), 1'b0);
            endcase
        end
    endtask

    task automatic send_quoted();
        send_unit(CU_QUOTE, 1'b0);
        send_string_body();
        send_unit(CU_QUOTE, 1'b0);
    endtask

    initial
    begin
        int rand_start;
        int drain;

        rst_n       = 1'b0;
        in_valid    = 1'b0;
        code_unit   = 16'h0000;
        end_of_text = 1'b0;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part. Parentheses and an atom ended by a close, a skipped
        // byte-order mark, then the smallest and largest code units as atom
        // characters, closed by end of text.
        send_text("(a)");
        send_unit(CU_BOM, 1'b0);
        send_unit(16'h0000, 1'b0);
        send_unit(16'hFFFF, 1'b0);
        send_end();
        // Every escape, an unknown one, a string join across whitespace onto
        // an empty string, and a lone plus that runs into the atom after it.
        send_text("\"\\n\\t\\\"\\\\\\q\"+ \"\"+b");
        send_end();
        // Text ending inside a string with a backslash still pending.
        send_text("\"\\");
        send_end();

        // Random part: mostly well-formed tokens with random content, with
        // some noise, stray byte-order marks and unterminated strings mixed in.
        rand_start = units_sent;
        while (units_sent - rand_start < RANDOM_UNITS)
        begin
            // One stretch in the middle runs with both sides never idling.
            steady = (units_sent - rand_start >= 150) &&
                     (units_sent - rand_start < 230);
            case ($urandom_range(0, 19))
                0, 1: send_unit(CU_OPEN, 1'b0);
                2, 3: send_unit(CU_CLOSE, 1'b0);
                4, 5, 6:
                    repeat ($urandom_range(1, 4))
                        send_unit(atom_unit(), 1'b0);
                7, 8, 9: send_blanks($urandom_range(1, 3));
                10, 11, 12, 13, 14:
                begin
                    send_quoted();
                    case ($urandom_range(0, 5))
                        0, 1:
                        begin
                            // Joined string, with whitespace on either side
                            // of the plus now and then.
                            if ($urandom_range(0, 1) != 0)
                                send_blanks(1);
                            send_unit(CU_PLUS, 1'b0);
                            if ($urandom_range(0, 1) != 0)
                                send_blanks(1);
                            send_quoted();
                        end
                        2:
                        begin
                            // A plus with no string after it.
                            if ($urandom_range(0, 1) != 0)
                                send_blanks(1);
                            send_unit(CU_PLUS, 1'b0);
                            if ($urandom_range(0, 1) != 0)
                                send_blanks(1);
                        end
                        default: ;
                    endcase
                end
                15: send_end();
                16: send_unit(16'($urandom_range(0, 16'hFFFF)), 1'b0);
                17:
                begin
                    // Unterminated string.
                    send_unit(CU_QUOTE, 1'b0);
                    send_string_body();
                    send_end();
                end
                18: send_unit(CU_BOM, 1'b0);
                default: send_unit(16'($urandom_range(0, 16'h00FF)), 1'b0);
            endcase
        end
        steady = 1'b0;
        send_end();
        @(negedge clk);
        in_valid <= 1'b0;

        // Let the output queue drain, then give the block a few more cycles
        // in which any stray event would show up.
        drain = 0;
        while (pending_events != 0 && drain < DRAIN_LIMIT)
        begin
            @(negedge clk);
            drain++;
        end
        repeat (10) @(negedge clk);

        if (fail_count == 0 && pending_events == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // Watchdog: the full run needs well under 2 ms.
    initial
    begin
        #(10_000_000);
        $display("Verification failed");
        $finish;
    end

endmodule
